// ----- hw/rtl/pip_pkg.sv -----
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants for the polygon classifier
// Request and result structs, command and location codes, and the control
// word of the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int MaxVerticesDef = 64;
  localparam int CoordBitsDef   = 16;

  localparam int CoordW = 16;
  localparam int TolW   = 17;
  localparam int MulW   = 19;
  localparam int AccW   = 72;

  localparam logic [1:0] CMD_CLEAR    = 2'd0;
  localparam logic [1:0] CMD_APPEND   = 2'd1;
  localparam logic [1:0] CMD_CLASSIFY = 2'd2;

  localparam logic [1:0] LOC_OUTSIDE  = 2'd0;
  localparam logic [1:0] LOC_BOUNDARY = 2'd1;
  localparam logic [1:0] LOC_INSIDE   = 2'd2;
  localparam logic [1:0] LOC_RSVD     = 2'd3;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
  } in_t;

  typedef struct packed {
    logic [1:0] location;
    logic       vertices_dropped;
  } out_t;

  typedef enum logic [1:0] {
    SH_0,
    SH_17,
    SH_34
  } mac_sh_t;

  typedef enum logic [3:0] {
    DST_NONE,
    DST_CROSS,
    DST_LEN2,
    DST_DOT,
    DST_DW,
    DST_DU,
    DST_C2,
    DST_TL2,
    DST_NUM,
    DST_T2
  } mac_dst_t;

  typedef struct packed {
    logic     vld;
    logic     first;
    logic     neg;
    mac_sh_t  sh;
    mac_dst_t dst;
  } mac_ctl_t;

endpackage

// ----- hw/rtl/pip_ram.sv -----
// ----------------------------------------------------------------------------
// pip_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module pip_ram #(
  parameter int DataW = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [DataW-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [DataW-1:0]         rd_data
);

  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hw/rtl/pip_mac.sv -----
// ----------------------------------------------------------------------------
// pip_mac: shared multiply-accumulate unit
// Registered 19x19 signed product, then a 72-bit accumulate with a selectable
// shift and sign; the destination tag comes out with the updated sum.
// ----------------------------------------------------------------------------
module pip_mac
  import pip_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic signed [MulW-1:0] op_a,
  input  logic signed [MulW-1:0] op_b,
  input  mac_ctl_t               ctl,
  output logic signed [AccW-1:0] acc,
  output mac_dst_t               acc_dst
);

  logic signed [2*MulW-1:0] prod_r;
  mac_ctl_t                 ctl_d_r;
  logic signed [AccW-1:0]   acc_r;
  logic signed [AccW-1:0]   acc_nxt;
  logic signed [AccW-1:0]   prod_ext;
  logic signed [AccW-1:0]   prod_sh;
  mac_dst_t                 dst_r;

  always_comb begin
    prod_ext = {{(AccW-2*MulW){prod_r[2*MulW-1]}}, prod_r};
    unique case (ctl_d_r.sh)
      SH_0:    prod_sh = prod_ext;
      SH_17:   prod_sh = prod_ext <<< 17;
      SH_34:   prod_sh = prod_ext <<< 34;
      default: prod_sh = prod_ext;
    endcase
    acc_nxt = (ctl_d_r.first ? '0 : acc_r) + (ctl_d_r.neg ? -prod_sh : prod_sh);
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (!rst_n) begin
      ctl_d_r <= '0;
      dst_r   <= DST_NONE;
    end else begin
      ctl_d_r <= ctl;
      dst_r   <= ctl_d_r.vld ? ctl_d_r.dst : DST_NONE;
      if (ctl_d_r.vld) begin
        acc_r <= acc_nxt;
      end
    end
  end

  assign acc     = acc_r;
  assign acc_dst = dst_r;

endmodule

// ----- hw/rtl/point_in_polygon_classify_core.sv -----
// ----------------------------------------------------------------------------
// point_in_polygon_classify_core: polygon store and point classifier
// Keeps a vertex list and classifies query points as outside, on the
// boundary or inside, with an exact squared-distance tolerance test.
// ----------------------------------------------------------------------------
// usage
//   in_valid/in_stall carries requests: clear, append vertex, classify point.
//   out_valid/out_stall returns one result per classify request only.
//   cfg_valid/cfg_ready writes the boundary tolerance; write it while idle.
// sequence
//   clear and append are handled in the idle state and leave it idle.
//   classify with n vertices walks the edges in turn; an edge that straddles
//   the query y also goes through the crossing divider. The walk stops early
//   at the first boundary hit. Each edge takes 19 products from the one shared
//   19x19 multiply-accumulate unit; the divider yields one bit per cycle.
//   in_stall is high while a classify request is in flight.
// reset
//   synchronous, active low: polygon empty, overflow flag and tolerance 0.
//   vertex memory is not cleared; only written entries are ever used.
// stall
//   a finished result waits in the output register; clear and append
//   requests are still taken meanwhile, a next classify waits at its end.
// ----------------------------------------------------------------------------
module point_in_polygon_classify_core
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = MaxVerticesDef,
  parameter int COORD_BITS   = CoordBitsDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  in_t             in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output out_t            out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [TolW-1:0] cfg_data
);

  localparam int AW   = $clog2(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int CW   = (COORD_BITS < CoordW) ? COORD_BITS : CoordW;
  localparam int CSH  = CoordW - CW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOADJ, ST_LOADI, ST_MUL, ST_DRAIN1, ST_DRAIN2,
    ST_EVAL, ST_DIV, ST_CMP, ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_EX_WY, OP_EY_WX, OP_EX_EX, OP_EY_EY, OP_EX_WX, OP_EY_WY,
    OP_WX_WX, OP_WY_WY, OP_UX_UX, OP_UY_UY,
    OP_CL_CL, OP_CH_CL_A, OP_CH_CL_B, OP_CH_CH,
    OP_TL_LL, OP_TH_LL, OP_TL_LH, OP_TH_LH,
    OP_NUM, OP_T2
  } op_t;

  state_t                 state_r;
  op_t                    op_r;
  logic [CNTW-1:0]        vcount_r;
  logic                   ovf_r;
  logic [TolW-1:0]        tol_r;
  logic                   out_valid_r;
  out_t                   out_data_r;
  logic [1:0]             loc_r;
  logic                   odd_r;
  logic [AW-1:0]          i_r;
  logic [4:0]             dcnt_r;

  logic signed [CoordW-1:0] px_r, py_r, ix_r, iy_r, jx_r, jy_r;
  logic signed [CoordW:0]   ex_r, ey_r, wx_r, wy_r, ux_r, uy_r;
  logic signed [34:0]       cross_r, dot_r, num_r;
  logic [33:0]              len2_r, dw_r, du_r, t2_r;
  logic [67:0]              c2_r, tl2_r;
  logic [31:0]              nmag_r, qmag_r;
  logic [15:0]              dmag_r, rem_r;
  logic                     qneg_r;

  logic                     in_acc;
  logic signed [CoordW-1:0] sx, sy;
  logic [AW-1:0]            rd_addr;
  logic [2*CoordW-1:0]      rd_data;
  logic                     wr_en;
  logic [34:0]              cmag;
  logic signed [MulW-1:0]   op_a, op_b;
  mac_ctl_t                 ctl;
  logic signed [AccW-1:0]   acc;
  mac_dst_t                 acc_dst;
  logic                     near, at_vertex, straddle, last_edge, out_free;
  logic [16:0]              trial;
  logic signed [33:0]       q_s, wx_s;
  logic signed [34:0]       nabs;
  logic signed [CoordW:0]   eabs;
  logic                     odd_cmp;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign sx = $signed(in_data.coord_x << CSH) >>> CSH;
  assign sy = $signed(in_data.coord_y << CSH) >>> CSH;

  assign wr_en = in_acc && (in_data.cmd == CMD_APPEND)
                 && (vcount_r < CNTW'(MAX_VERTICES));

  assign last_edge = ((CNTW'(i_r) + CNTW'(1)) == vcount_r);

  always_comb begin
    unique case (state_r)
      ST_IDLE:  rd_addr = AW'(vcount_r - CNTW'(1));
      ST_LOADJ: rd_addr = '0;
      default:  rd_addr = AW'(i_r + AW'(1));
    endcase
  end

  pip_ram #(
    .DataW (2*CoordW),
    .Depth (MAX_VERTICES)
  ) u_vram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(vcount_r)),
    .wr_data ({sx, sy}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // operand and control selection for the shared unit
  always_comb begin
    cmag = cross_r[34] ? 35'(-cross_r) : 35'(cross_r);
    op_a = '0;
    op_b = '0;
    ctl  = '{vld: 1'b0, first: 1'b0, neg: 1'b0, sh: SH_0, dst: DST_NONE};
    if (state_r == ST_MUL || state_r == ST_LOADJ) begin
      ctl.vld = 1'b1;
      unique case (state_r == ST_LOADJ ? OP_T2 : op_r)
        OP_EX_WY: begin
          op_a = MulW'(ex_r); op_b = MulW'(wy_r); ctl.first = 1'b1;
        end
        OP_EY_WX: begin
          op_a = MulW'(ey_r); op_b = MulW'(wx_r); ctl.neg = 1'b1; ctl.dst = DST_CROSS;
        end
        OP_EX_EX: begin
          op_a = MulW'(ex_r); op_b = MulW'(ex_r); ctl.first = 1'b1;
        end
        OP_EY_EY: begin
          op_a = MulW'(ey_r); op_b = MulW'(ey_r); ctl.dst = DST_LEN2;
        end
        OP_EX_WX: begin
          op_a = MulW'(ex_r); op_b = MulW'(wx_r); ctl.first = 1'b1;
        end
        OP_EY_WY: begin
          op_a = MulW'(ey_r); op_b = MulW'(wy_r); ctl.dst = DST_DOT;
        end
        OP_WX_WX: begin
          op_a = MulW'(wx_r); op_b = MulW'(wx_r); ctl.first = 1'b1;
        end
        OP_WY_WY: begin
          op_a = MulW'(wy_r); op_b = MulW'(wy_r); ctl.dst = DST_DW;
        end
        OP_UX_UX: begin
          op_a = MulW'(ux_r); op_b = MulW'(ux_r); ctl.first = 1'b1;
        end
        OP_UY_UY: begin
          op_a = MulW'(uy_r); op_b = MulW'(uy_r); ctl.dst = DST_DU;
        end
        OP_CL_CL: begin
          op_a = {2'b0, cmag[16:0]}; op_b = {2'b0, cmag[16:0]}; ctl.first = 1'b1;
        end
        OP_CH_CL_A, OP_CH_CL_B: begin
          op_a = {1'b0, cmag[34:17]}; op_b = {2'b0, cmag[16:0]}; ctl.sh = SH_17;
        end
        OP_CH_CH: begin
          op_a = {1'b0, cmag[34:17]}; op_b = {1'b0, cmag[34:17]};
          ctl.sh = SH_34; ctl.dst = DST_C2;
        end
        OP_TL_LL: begin
          op_a = {2'b0, t2_r[16:0]}; op_b = {2'b0, len2_r[16:0]}; ctl.first = 1'b1;
        end
        OP_TH_LL: begin
          op_a = {2'b0, t2_r[33:17]}; op_b = {2'b0, len2_r[16:0]}; ctl.sh = SH_17;
        end
        OP_TL_LH: begin
          op_a = {2'b0, t2_r[16:0]}; op_b = {2'b0, len2_r[33:17]}; ctl.sh = SH_17;
        end
        OP_TH_LH: begin
          op_a = {2'b0, t2_r[33:17]}; op_b = {2'b0, len2_r[33:17]};
          ctl.sh = SH_34; ctl.dst = DST_TL2;
        end
        OP_NUM: begin
          op_a = MulW'(wy_r); op_b = MulW'(ex_r); ctl.first = 1'b1; ctl.dst = DST_NUM;
        end
        OP_T2: begin
          op_a = {2'b0, tol_r}; op_b = {2'b0, tol_r}; ctl.first = 1'b1; ctl.dst = DST_T2;
        end
        default: ctl.vld = 1'b0;
      endcase
    end
  end

  pip_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .op_a    (op_a),
    .op_b    (op_b),
    .ctl     (ctl),
    .acc     (acc),
    .acc_dst (acc_dst)
  );

  // edge decision and crossing divider
  always_comb begin
    if (dot_r <= 35'sd0) begin
      near = (dw_r <= t2_r);
    end else if (dot_r >= $signed({1'b0, len2_r})) begin
      near = (du_r <= t2_r);
    end else begin
      near = (c2_r <= tl2_r);
    end
    at_vertex = (wx_r == '0 && wy_r == '0) || (ux_r == '0 && uy_r == '0);
    straddle  = (wy_r > 0 && uy_r <= 0) || (wy_r <= 0 && uy_r > 0);
    nabs      = num_r[34] ? -num_r : num_r;
    eabs      = ey_r[CoordW] ? -ey_r : ey_r;
    trial     = {rem_r, nmag_r[31]};
    q_s       = qneg_r ? -$signed({2'b0, qmag_r}) : $signed({2'b0, qmag_r});
    wx_s      = 34'(wx_r);
    odd_cmp   = odd_r ^ (q_s > wx_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_EX_WY;
      vcount_r    <= '0;
      ovf_r       <= 1'b0;
      tol_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tol_r <= cfg_data;
      end
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (acc_dst)
        DST_CROSS: cross_r <= acc[34:0];
        DST_LEN2:  len2_r  <= acc[33:0];
        DST_DOT:   dot_r   <= acc[34:0];
        DST_DW:    dw_r    <= acc[33:0];
        DST_DU:    du_r    <= acc[33:0];
        DST_C2:    c2_r    <= acc[67:0];
        DST_TL2:   tl2_r   <= acc[67:0];
        DST_NUM:   num_r   <= acc[34:0];
        DST_T2:    t2_r    <= acc[33:0];
        default: ;
      endcase

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            priority if (in_data.cmd == CMD_CLEAR) begin
              vcount_r <= '0;
              ovf_r    <= 1'b0;
            end else if (in_data.cmd == CMD_APPEND) begin
              if (wr_en) begin
                vcount_r <= vcount_r + CNTW'(1);
              end else begin
                ovf_r <= 1'b1;
              end
            end else if (in_data.cmd == CMD_CLASSIFY) begin
              px_r  <= sx;
              py_r  <= sy;
              i_r   <= '0;
              odd_r <= 1'b0;
              if (vcount_r == '0) begin
                loc_r   <= LOC_OUTSIDE;
                state_r <= ST_DONE;
              end else begin
                state_r <= ST_LOADJ;
              end
            end else begin
            end
          end
        end
        ST_LOADJ: begin
          jx_r    <= rd_data[2*CoordW-1:CoordW];
          jy_r    <= rd_data[CoordW-1:0];
          state_r <= ST_LOADI;
        end
        ST_LOADI: begin
          ix_r    <= rd_data[2*CoordW-1:CoordW];
          iy_r    <= rd_data[CoordW-1:0];
          ex_r    <= (CoordW+1)'(jx_r) - (CoordW+1)'($signed(rd_data[2*CoordW-1:CoordW]));
          ey_r    <= (CoordW+1)'(jy_r) - (CoordW+1)'($signed(rd_data[CoordW-1:0]));
          wx_r    <= (CoordW+1)'(px_r) - (CoordW+1)'($signed(rd_data[2*CoordW-1:CoordW]));
          wy_r    <= (CoordW+1)'(py_r) - (CoordW+1)'($signed(rd_data[CoordW-1:0]));
          ux_r    <= (CoordW+1)'(px_r) - (CoordW+1)'(jx_r);
          uy_r    <= (CoordW+1)'(py_r) - (CoordW+1)'(jy_r);
          op_r    <= OP_EX_WY;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          if (op_r == OP_NUM) begin
            state_r <= ST_DRAIN1;
          end else begin
            op_r <= op_t'(op_r + 5'd1);
          end
        end
        ST_DRAIN1: state_r <= ST_DRAIN2;
        ST_DRAIN2: state_r <= ST_EVAL;
        ST_EVAL: begin
          priority if (near || at_vertex) begin
            loc_r   <= LOC_BOUNDARY;
            state_r <= ST_DONE;
          end else if (straddle) begin
            nmag_r  <= nabs[31:0];
            dmag_r  <= eabs[15:0];
            qneg_r  <= num_r[34] ^ ey_r[CoordW];
            rem_r   <= '0;
            qmag_r  <= '0;
            dcnt_r  <= '0;
            state_r <= ST_DIV;
          end else if (last_edge) begin
            loc_r   <= odd_r ? LOC_INSIDE : LOC_OUTSIDE;
            state_r <= ST_DONE;
          end else begin
            jx_r    <= ix_r;
            jy_r    <= iy_r;
            i_r     <= AW'(i_r + AW'(1));
            state_r <= ST_LOADI;
          end
        end
        ST_DIV: begin
          nmag_r <= {nmag_r[30:0], 1'b0};
          if (trial >= {1'b0, dmag_r}) begin
            rem_r  <= 16'(trial - {1'b0, dmag_r});
            qmag_r <= {qmag_r[30:0], 1'b1};
          end else begin
            rem_r  <= trial[15:0];
            qmag_r <= {qmag_r[30:0], 1'b0};
          end
          dcnt_r <= dcnt_r + 5'd1;
          if (dcnt_r == 5'd31) begin
            state_r <= ST_CMP;
          end
        end
        ST_CMP: begin
          priority if (q_s == wx_s) begin
            loc_r   <= LOC_BOUNDARY;
            state_r <= ST_DONE;
          end else if (last_edge) begin
            loc_r   <= odd_cmp ? LOC_INSIDE : LOC_OUTSIDE;
            state_r <= ST_DONE;
          end else begin
            odd_r   <= odd_cmp;
            jx_r    <= ix_r;
            jy_r    <= iy_r;
            i_r     <= AW'(i_r + AW'(1));
            state_r <= ST_LOADI;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r                 <= 1'b1;
            out_data_r.location         <= loc_r;
            out_data_r.vertices_dropped <= ovf_r;
            state_r                     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_loc_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.location != LOC_RSVD)
    else $error("reserved location code on output");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vcount_r <= CNTW'(MAX_VERTICES))
    else $error("vertex count past capacity");

  a_mac_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EVAL |-> acc_dst == DST_NONE)
    else $error("edge decision taken before products settled");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> dmag_r != '0)
    else $error("crossing division by zero");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside of done");
`endif

endmodule
